// ===== src/gpb_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// gpb_pkg
// shared types and constants for the goal post pair and ball selector
// ----------------------------------------------------------------------------
`default_nettype none
package gpb_pkg;
    localparam int unsigned DefMaxPosts = 16;
    localparam int unsigned CfgIdxW = 2;
    localparam logic [CfgIdxW-1:0] REG_GOAL_WIDTH = 2'd0;
    localparam logic [CfgIdxW-1:0] REG_GATE = 2'd1;
    localparam logic [CfgIdxW-1:0] REG_BALL_MIN = 2'd2;
    localparam logic [CfgIdxW-1:0] REG_BALL_MAX = 2'd3;
    localparam logic [2:0] LABEL_POST = 3'd1;
    localparam logic [2:0] LABEL_BALL = 3'd2;

    typedef struct packed {
        logic [2:0]         seg_label;
        logic               features_ok;
        logic signed [15:0] seg_x;
        logic signed [15:0] seg_y;
        logic               last_segment;
    } t_seg;

    typedef struct packed {
        logic               ball_found;
        logic signed [15:0] ball_x;
        logic signed [15:0] ball_y;
        logic [1:0]         post_count;
        logic signed [15:0] post_a_x;
        logic signed [15:0] post_a_y;
        logic signed [15:0] post_b_x;
        logic signed [15:0] post_b_y;
        logic               post_overflow;
    } t_res;

    typedef struct packed {
        logic [CfgIdxW-1:0] index;
        logic [15:0]        data;
    } t_cfg;
endpackage
`default_nettype wire

// ===== src/gpb_if.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// gpb_if
// generic valid/ready channel carrying one payload type
// ----------------------------------------------------------------------------
`default_nettype none
interface gpb_if #(parameter type T = logic);
    logic valid;
    logic ready;
    T     data;
    modport source (output valid, output data, input ready);
    modport sink (input valid, input data, output ready);
endinterface
`default_nettype wire

// ===== src/goal_post_pair_and_ball_select.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// goal_post_pair_and_ball_select
// ball and goal post pair selection over the segments of one scan
// ----------------------------------------------------------------------------
// usage:
//   i_seg carries one classified segment per transaction, i_cfg writes one of
//   four 16-bit registers (index 0 goal width, 1 gate, 2 ball min, 3 ball max),
//   o_res carries one result after each segment marked last_segment.
//   a normal segment passes through accept, squared distance and ball compare /
//   post store write. the post store is a simple dual-port synchronous memory
//   (one write port, one read port).
//   after the last segment the pair search reads both posts of each pair from
//   the store, one after the other, and runs a one-root-bit-per-cycle square
//   root on the squared distance between them.
//   the result sits in an output register; while the receiver stalls the
//   block holds it and accepts no further segment.
//   reset restores the register defaults and clears the per-scan state; the
//   store needs no clearing since only entries below the fill count are read.
// ----------------------------------------------------------------------------
`default_nettype none
module goal_post_pair_and_ball_select
    import gpb_pkg::*;
#(
    parameter int unsigned MAX_POSTS = DefMaxPosts
) (
    input  wire  i_clk,
    input  wire  i_rst_n,
    gpb_if.sink   i_seg,
    gpb_if.sink   i_cfg,
    gpb_if.source o_res
);
    localparam int unsigned AW = (MAX_POSTS > 1) ? $clog2(MAX_POSTS) : 1;
    localparam int unsigned CW = $clog2(MAX_POSTS + 1);

    // states
    localparam logic [3:0] S_IDLE = 4'd0;
    localparam logic [3:0] S_SQ   = 4'd1;
    localparam logic [3:0] S_UPD  = 4'd2;
    localparam logic [3:0] S_PRE  = 4'd3;
    localparam logic [3:0] S_RDI  = 4'd4;
    localparam logic [3:0] S_RDJ  = 4'd5;
    localparam logic [3:0] S_DIF  = 4'd6;
    localparam logic [3:0] S_MUL  = 4'd7;
    localparam logic [3:0] S_SQRT = 4'd8;
    localparam logic [3:0] S_CMP  = 4'd9;
    localparam logic [3:0] S_FIN  = 4'd10;
    localparam logic [3:0] S_FA   = 4'd11;
    localparam logic [3:0] S_FB   = 4'd12;
    localparam logic [3:0] S_OUT  = 4'd13;

    logic [3:0] r_st;
    logic [15:0] r_goal, r_gate, r_bmin, r_bmax;

    // post store
    logic [31:0] mem [MAX_POSTS];
    logic        r_we;
    logic [AW-1:0] r_waddr, r_raddr;
    logic [31:0] r_wdata, r_rdata;

    always_ff @(posedge i_clk) begin
        if (r_we) begin
            mem[r_waddr] <= r_wdata;
        end
        r_rdata <= mem[r_raddr];
    end

    t_seg r_seg;
    logic [31:0] r_d2, r_lo, r_hi;
    logic r_bhave, r_ovf;
    logic signed [15:0] r_bx, r_by;
    logic [31:0] r_bd2;
    logic [CW-1:0] r_cnt;

    // pair search
    logic [AW-1:0] r_i, r_j, r_bi, r_bj;
    logic signed [15:0] r_ix, r_iy;
    logic signed [16:0] r_dx, r_dy;
    logic [33:0] r_n, r_root, r_bit;
    logic [4:0]  r_k;
    logic [16:0] r_berr;
    logic        r_any;
    t_res        r_res;

    logic [33:0] w_trial;
    logic [16:0] w_s, w_err;
    logic        w_store, w_take, w_keep;
    assign w_trial = r_root + r_bit;
    assign w_s = r_root[16:0];
    assign w_err = (w_s >= {1'b0, r_goal}) ? w_s - {1'b0, r_goal} : {1'b0, r_goal} - w_s;
    // segment goes into the post store
    assign w_store = r_seg.features_ok && (r_seg.seg_label == LABEL_POST)
                     && (r_cnt < CW'(MAX_POSTS));
    // current pair becomes the best one
    assign w_take = !r_any || (w_err < r_berr);
    // first post is reported
    assign w_keep = (r_cnt == CW'(1)) || (r_cnt >= CW'(2) && r_berr <= {1'b0, r_gate});

    assign i_seg.ready = (r_st == S_IDLE);
    assign i_cfg.ready = 1'b1;
    assign o_res.valid = (r_st == S_OUT);
    assign o_res.data  = r_res;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_st <= S_IDLE;
            r_goal <= 16'd900;
            r_gate <= 16'd150;
            r_bmin <= 16'd200;
            r_bmax <= 16'd1500;
            r_we <= 1'b0;
            r_cnt <= '0;
            r_bhave <= 1'b0;
            r_bx <= '0;
            r_by <= '0;
            r_bd2 <= '1;
            r_ovf <= 1'b0;
        end else begin
            if (i_cfg.valid) begin
                case (i_cfg.data.index)
                    REG_GOAL_WIDTH: r_goal <= i_cfg.data.data;
                    REG_GATE:       r_gate <= i_cfg.data.data;
                    REG_BALL_MIN:   r_bmin <= i_cfg.data.data;
                    REG_BALL_MAX:   r_bmax <= i_cfg.data.data;
                    default: ;
                endcase
            end
            case (r_st)
                S_IDLE: begin
                    r_we <= 1'b0;
                    if (i_seg.valid) begin
                        r_seg <= i_seg.data;
                        r_st <= S_SQ;
                    end
                end
                S_SQ: begin
                    r_d2 <= 32'(r_seg.seg_x * r_seg.seg_x);
                    r_lo <= r_bmin * r_bmin;
                    r_hi <= r_bmax * r_bmax;
                    r_st <= S_UPD;
                end
                S_UPD: begin
                    r_we <= w_store;
                    if (r_seg.features_ok) begin
                        if (r_seg.seg_label == LABEL_BALL && r_seg.seg_y > 0) begin
                            if (r_d2 + 32'(r_seg.seg_y * r_seg.seg_y) < r_bd2
                                && r_d2 + 32'(r_seg.seg_y * r_seg.seg_y) > r_lo
                                && r_d2 + 32'(r_seg.seg_y * r_seg.seg_y) < r_hi) begin
                                r_bd2 <= r_d2 + 32'(r_seg.seg_y * r_seg.seg_y);
                                r_bhave <= 1'b1;
                                r_bx <= r_seg.seg_x;
                                r_by <= r_seg.seg_y;
                            end
                        end else if (r_seg.seg_label == LABEL_POST) begin
                            if (r_cnt < CW'(MAX_POSTS)) begin
                                r_waddr <= r_cnt[AW-1:0];
                                r_wdata <= {r_seg.seg_x, r_seg.seg_y};
                                r_cnt <= r_cnt + 1'b1;
                            end else begin
                                r_ovf <= 1'b1;
                            end
                        end
                    end
                    r_st <= r_seg.last_segment ? S_PRE : S_IDLE;
                end
                S_PRE: begin
                    // store write lands this cycle
                    r_we <= 1'b0;
                    r_any <= 1'b0;
                    r_i <= '0;
                    r_j <= AW'(1);
                    r_bi <= '0;
                    r_bj <= AW'(1);
                    r_raddr <= '0;
                    r_st <= (r_cnt >= CW'(2)) ? S_RDI : S_FIN;
                end
                S_RDI: begin
                    r_raddr <= r_j;
                    r_st <= S_RDJ;
                end
                S_RDJ: begin
                    r_ix <= r_rdata[31:16];
                    r_iy <= r_rdata[15:0];
                    r_st <= S_DIF;
                end
                S_DIF: begin
                    r_dx <= 17'(r_ix) - 17'($signed(r_rdata[31:16]));
                    r_dy <= 17'(r_iy) - 17'($signed(r_rdata[15:0]));
                    r_st <= S_MUL;
                end
                S_MUL: begin
                    r_n <= 34'(r_dx * r_dx) + 34'(r_dy * r_dy);
                    r_root <= '0;
                    r_bit <= 34'd1 << 32;
                    r_k <= 5'd17;
                    r_st <= S_SQRT;
                end
                S_SQRT: begin
                    if (r_n >= w_trial) begin
                        r_n <= r_n - w_trial;
                        r_root <= (r_root >> 1) + r_bit;
                    end else begin
                        r_root <= r_root >> 1;
                    end
                    r_bit <= r_bit >> 2;
                    r_k <= r_k - 1'b1;
                    if (r_k == 5'd1) begin
                        r_st <= S_CMP;
                    end
                end
                S_CMP: begin
                    if (w_take) begin
                        r_any <= 1'b1;
                        r_berr <= w_err;
                        r_bi <= r_i;
                        r_bj <= r_j;
                    end
                    if (CW'(r_j) + 1'b1 < r_cnt) begin
                        r_j <= r_j + 1'b1;
                        r_raddr <= r_i;
                        r_st <= S_RDI;
                    end else if (CW'(r_i) + CW'(2) < r_cnt) begin
                        r_i <= r_i + 1'b1;
                        r_j <= r_i + AW'(2);
                        r_raddr <= r_i + 1'b1;
                        r_st <= S_RDI;
                    end else begin
                        if (w_take) begin
                            r_raddr <= r_i;
                        end else begin
                            r_raddr <= r_bi;
                        end
                        r_st <= S_FIN;
                    end
                end
                S_FIN: begin
                    // r_raddr holds entry 0 or the first post of the best pair
                    r_raddr <= r_bj;
                    r_st <= S_FA;
                end
                S_FA: begin
                    r_res.ball_found <= r_bhave;
                    r_res.ball_x <= r_bx;
                    r_res.ball_y <= r_by;
                    r_res.post_overflow <= r_ovf;
                    r_res.post_b_x <= '0;
                    r_res.post_b_y <= '0;
                    if (w_keep) begin
                        r_res.post_a_x <= r_rdata[31:16];
                        r_res.post_a_y <= r_rdata[15:0];
                    end else begin
                        r_res.post_a_x <= '0;
                        r_res.post_a_y <= '0;
                    end
                    if (r_cnt == CW'(1)) begin
                        r_res.post_count <= 2'd1;
                    end else if (w_keep) begin
                        r_res.post_count <= 2'd2;
                    end else begin
                        r_res.post_count <= 2'd0;
                    end
                    r_st <= S_FB;
                end
                S_FB: begin
                    if (r_res.post_count == 2'd2) begin
                        r_res.post_b_x <= r_rdata[31:16];
                        r_res.post_b_y <= r_rdata[15:0];
                    end
                    r_cnt <= '0;
                    r_bhave <= 1'b0;
                    r_bx <= '0;
                    r_by <= '0;
                    r_bd2 <= '1;
                    r_ovf <= 1'b0;
                    r_st <= S_OUT;
                end
                S_OUT: begin
                    if (o_res.ready) begin
                        r_st <= S_IDLE;
                    end
                end
                default: r_st <= S_IDLE;
            endcase
        end
    end
endmodule
`default_nettype wire

// ===== tb/sv/goal_post_pair_and_ball_select_tb.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// goal_post_pair_and_ball_select_tb
// self-checking bench for the goal post pair and ball selector
// ----------------------------------------------------------------------------
// drives scans of classified segments over the segment channel, writes the
// four registers between scans, and compares each result transaction field by
// field against a scan predictor kept in a small scoreboard class. the sender
// and receiver idle at random in the first two phases, not in the third.
// ----------------------------------------------------------------------------
`default_nettype none
module goal_post_pair_and_ball_select_tb;
    import gpb_pkg::*;

    localparam int NPOSTS = DefMaxPosts;
    localparam longint CYCLE_LIMIT = 3000000;

    // scoreboard: scan predictor plus queue of expected scan results
    class scan_scoreboard;
        logic [15:0] gap_mm, gate, ball_min, ball_max;
        logic signed [15:0] post_x[NPOSTS];
        logic signed [15:0] post_y[NPOSTS];
        int unsigned n_posts;
        bit have_ball, overflow;
        logic signed [15:0] best_x, best_y;
        logic [31:0] best_d2;
        t_res expected_q[$];
        int errors;

        function void clear_scan();
            n_posts = 0;
            have_ball = 0;
            best_x = 0;
            best_y = 0;
            best_d2 = '1;
            overflow = 0;
        endfunction

        function void reset_all();
            gap_mm = 900;
            gate = 150;
            ball_min = 200;
            ball_max = 1500;
            clear_scan();
        endfunction

        function void write_reg(logic [CfgIdxW-1:0] idx, logic [15:0] val);
            case (idx)
                REG_GOAL_WIDTH: gap_mm = val;
                REG_GATE:       gate = val;
                REG_BALL_MIN:   ball_min = val;
                REG_BALL_MAX:   ball_max = val;
                default: ;
            endcase
        endfunction

        function longint unsigned root_floor(longint unsigned n);
            longint unsigned r, b;
            r = 0;
            b = 64'd1 << 62;
            while (b > n) b >>= 2;
            while (b != 0) begin
                if (n >= r + b) begin
                    n -= r + b;
                    r = (r >> 1) + b;
                end else begin
                    r >>= 1;
                end
                b >>= 2;
            end
            return r;
        endfunction

        // note one accepted segment
        function void note_segment(t_seg s);
            logic [31:0] d2, lo, hi;
            longint dx, dy;
            longint unsigned sp, err, low_err;
            int bi, bj;
            t_res r;
            if (s.features_ok) begin
                if (s.seg_label == LABEL_BALL && s.seg_y > 0) begin
                    d2 = 32'(longint'(s.seg_x) * s.seg_x + longint'(s.seg_y) * s.seg_y);
                    lo = 32'(ball_min) * 32'(ball_min);
                    hi = 32'(ball_max) * 32'(ball_max);
                    if (d2 < best_d2 && d2 > lo && d2 < hi) begin
                        best_d2 = d2;
                        have_ball = 1;
                        best_x = s.seg_x;
                        best_y = s.seg_y;
                    end
                end else if (s.seg_label == LABEL_POST) begin
                    if (n_posts < NPOSTS) begin
                        post_x[n_posts] = s.seg_x;
                        post_y[n_posts] = s.seg_y;
                        n_posts++;
                    end else begin
                        overflow = 1;
                    end
                end
            end
            if (!s.last_segment) return;
            r = '0;
            if (n_posts == 1) begin
                r.post_count = 2'd1;
                r.post_a_x = post_x[0];
                r.post_a_y = post_y[0];
            end else if (n_posts >= 2) begin
                low_err = 0;
                bi = 0;
                bj = 1;
                for (int i = 0; i < n_posts; i++) begin
                    for (int j = i + 1; j < n_posts; j++) begin
                        dx = longint'(post_x[i]) - post_x[j];
                        dy = longint'(post_y[i]) - post_y[j];
                        sp = root_floor(dx * dx + dy * dy);
                        err = sp >= gap_mm ? sp - gap_mm : gap_mm - sp;
                        if ((i == 0 && j == 1) || err < low_err) begin
                            low_err = err;
                            bi = i;
                            bj = j;
                        end
                    end
                end
                if (low_err <= gate) begin
                    r.post_count = 2'd2;
                    r.post_a_x = post_x[bi];
                    r.post_a_y = post_y[bi];
                    r.post_b_x = post_x[bj];
                    r.post_b_y = post_y[bj];
                end
            end
            r.ball_found = have_ball;
            r.ball_x = have_ball ? best_x : 16'sd0;
            r.ball_y = have_ball ? best_y : 16'sd0;
            r.post_overflow = overflow;
            expected_q = {expected_q, r};
            clear_scan();
        endfunction

        // compare one result transaction with the oldest expectation
        function void check_result(t_res got);
            t_res exp_r;
            if (expected_q.size() == 0) begin
                $display("%0t unexpected result exp none got %h", $time, got);
                errors++;
                return;
            end
            exp_r = expected_q.pop_front();
            if (got.ball_found !== exp_r.ball_found)
                $display("%0t ball_found exp %0d got %0d", $time, exp_r.ball_found, got.ball_found);
            if (got.ball_x !== exp_r.ball_x)
                $display("%0t ball_x exp %0d got %0d", $time, exp_r.ball_x, got.ball_x);
            if (got.ball_y !== exp_r.ball_y)
                $display("%0t ball_y exp %0d got %0d", $time, exp_r.ball_y, got.ball_y);
            if (got.post_count !== exp_r.post_count)
                $display("%0t post_count exp %0d got %0d", $time, exp_r.post_count, got.post_count);
            if (got.post_a_x !== exp_r.post_a_x)
                $display("%0t post_a_x exp %0d got %0d", $time, exp_r.post_a_x, got.post_a_x);
            if (got.post_a_y !== exp_r.post_a_y)
                $display("%0t post_a_y exp %0d got %0d", $time, exp_r.post_a_y, got.post_a_y);
            if (got.post_b_x !== exp_r.post_b_x)
                $display("%0t post_b_x exp %0d got %0d", $time, exp_r.post_b_x, got.post_b_x);
            if (got.post_b_y !== exp_r.post_b_y)
                $display("%0t post_b_y exp %0d got %0d", $time, exp_r.post_b_y, got.post_b_y);
            if (got.post_overflow !== exp_r.post_overflow)
                $display("%0t post_overflow exp %0d got %0d", $time, exp_r.post_overflow,
                         got.post_overflow);
            if (got !== exp_r) errors++;
        endfunction
    endclass

    logic i_clk;
    logic i_rst_n;
    gpb_if #(.T(t_seg)) seg_ch ();
    gpb_if #(.T(t_cfg)) cfg_ch ();
    gpb_if #(.T(t_res)) res_ch ();

    goal_post_pair_and_ball_select dut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_seg   (seg_ch.sink),
        .i_cfg   (cfg_ch.sink),
        .o_res   (res_ch.source)
    );

    scan_scoreboard sb;
    int send_idle_pct;
    int recv_idle_pct;
    longint cycles;
    int seg_count;

    initial begin
        i_clk = 0;
        forever #6 i_clk = ~i_clk;
    end

    // receiver: random ready, check each result transaction at the edge
    initial begin
        res_ch.ready = 0;
        forever begin
            @(posedge i_clk);
            if (i_rst_n && res_ch.valid && res_ch.ready) sb.check_result(res_ch.data);
            res_ch.ready <= ($urandom_range(99) >= recv_idle_pct);
        end
    end

    // watchdog on total cycles
    initial begin
        cycles = 0;
        forever begin
            @(posedge i_clk);
            cycles++;
            if (cycles > CYCLE_LIMIT) begin
                $display("status: fail");
                $finish;
            end
        end
    end

    // send one segment, with a random idle gap before it; valid stays high
    // after the transaction so segments can follow back to back
    task automatic send_seg(t_seg s);
        while ($urandom_range(99) < send_idle_pct) begin
            seg_ch.valid <= 0;
            @(posedge i_clk);
        end
        seg_ch.valid <= 1;
        seg_ch.data <= s;
        do @(posedge i_clk); while (!seg_ch.ready);
        sb.note_segment(s);
        seg_count++;
    endtask

    task automatic write_cfg(logic [CfgIdxW-1:0] idx, logic [15:0] val);
        cfg_ch.valid <= 1;
        cfg_ch.data <= '{index: idx, data: val};
        do @(posedge i_clk); while (!cfg_ch.ready);
        sb.write_reg(idx, val);
        cfg_ch.valid <= 0;
        @(posedge i_clk);
    endtask

    // wait for every expected result, then let any tail work finish
    task automatic drain();
        seg_ch.valid <= 0;
        while (sb.expected_q.size() != 0) @(posedge i_clk);
        repeat (40) @(posedge i_clk);
    endtask

    function automatic t_seg make_seg(logic [2:0] lab, logic ok, int x, int y, logic last);
        t_seg s;
        s.seg_label = lab;
        s.features_ok = ok;
        s.seg_x = 16'(x);
        s.seg_y = 16'(y);
        s.last_segment = last;
        return s;
    endfunction

    function automatic int rnd16();
        return int'($signed(16'($urandom)));
    endfunction

    // one random scan; mostly posts and balls in a plausible range
    task automatic random_scan();
        int n;
        int kind;
        t_seg s;
        n = $urandom_range(1, 100) <= 5 ? $urandom_range(17, 22) : $urandom_range(1, 8);
        for (int k = 0; k < n; k++) begin
            kind = $urandom_range(99);
            if (kind < 40) begin
                s = make_seg(LABEL_POST, 1'b1, $urandom_range(0, 3000) - 1500,
                             $urandom_range(0, 3000) - 1500, 1'b0);
            end else if (kind < 75) begin
                s = make_seg(LABEL_BALL, 1'b1, $urandom_range(0, 3000) - 1500,
                             $urandom_range(0, 2000) - 300, 1'b0);
            end else begin
                s.seg_label = 3'($urandom_range(7));
                s.features_ok = 1'($urandom_range(1));
                s.seg_x = 16'(rnd16());
                s.seg_y = 16'(rnd16());
            end
            s.last_segment = (k == n - 1);
            send_seg(s);
        end
    endtask

    initial begin
        sb = new();
        sb.reset_all();
        sb.errors = 0;
        seg_count = 0;
        send_idle_pct = 17;
        recv_idle_pct = 52;
        i_rst_n = 0;
        seg_ch.valid = 0;
        seg_ch.data = '0;
        cfg_ch.valid = 0;
        cfg_ch.data = '0;
        repeat (8) @(posedge i_clk);
        i_rst_n <= 1;
        @(posedge i_clk);

        // directed: empty scan, lone post, an exact pair, ball extremes
        send_seg(make_seg(3'd0, 1'b1, 0, 0, 1'b1));
        send_seg(make_seg(LABEL_POST, 1'b1, -32768, 32767, 1'b1));
        send_seg(make_seg(LABEL_POST, 1'b1, 0, 1000, 1'b0));
        send_seg(make_seg(LABEL_POST, 1'b1, 900, 1000, 1'b0));
        send_seg(make_seg(LABEL_BALL, 1'b1, 0, 500, 1'b0));
        send_seg(make_seg(LABEL_BALL, 1'b1, 500, 0, 1'b0));
        send_seg(make_seg(LABEL_BALL, 1'b1, 0, -500, 1'b0));
        send_seg(make_seg(LABEL_BALL, 1'b1, -500, 0 + 1, 1'b0));
        send_seg(make_seg(LABEL_BALL, 1'b0, 0, 300, 1'b0));
        send_seg(make_seg(3'd7, 1'b1, 0, 300, 1'b0));
        send_seg(make_seg(LABEL_BALL, 1'b1, 0, 200, 1'b1));
        // far pair and extremes: no post within gate
        send_seg(make_seg(LABEL_POST, 1'b1, -32768, -32768, 1'b0));
        send_seg(make_seg(LABEL_POST, 1'b1, 32767, 32767, 1'b0));
        send_seg(make_seg(LABEL_BALL, 1'b1, 32767, 32767, 1'b1));
        // store overflow: 17 posts
        for (int k = 0; k < NPOSTS + 1; k++)
            send_seg(make_seg(LABEL_POST, 1'b1, k * 100, 50, k == NPOSTS));
        drain();

        // register extremes and inverted ball range
        write_cfg(REG_GOAL_WIDTH, 16'hFFFF);
        write_cfg(REG_GATE, 16'hFFFF);
        write_cfg(REG_BALL_MIN, 16'hFFFF);
        write_cfg(REG_BALL_MAX, 16'h0000);
        for (int k = 0; k < 100; k++) random_scan();
        drain();
        write_cfg(REG_GOAL_WIDTH, 16'h0000);
        write_cfg(REG_GATE, 16'h0000);
        write_cfg(REG_BALL_MIN, 16'h0000);
        write_cfg(REG_BALL_MAX, 16'hFFFF);
        for (int k = 0; k < 100; k++) random_scan();
        drain();

        send_idle_pct = 52;
        recv_idle_pct = 17;
        write_cfg(REG_GOAL_WIDTH, 16'd900);
        write_cfg(REG_GATE, 16'd150);
        write_cfg(REG_BALL_MIN, 16'd200);
        write_cfg(REG_BALL_MAX, 16'd1500);
        for (int k = 0; k < 100; k++) random_scan();
        drain();

        send_idle_pct = 0;
        recv_idle_pct = 0;
        while (seg_count < 2000) begin
            write_cfg(CfgIdxW'($urandom_range(3)), 16'($urandom_range(0, 2500)));
            for (int k = 0; k < 40; k++) random_scan();
            drain();
        end

        drain();
        if (sb.errors == 0 && sb.expected_q.size() == 0) begin
            $display("status: pass");
        end else begin
            $display("status: fail");
        end
        $finish;
    end
endmodule
`default_nettype wire

// ===== files.f =====
src/gpb_pkg.sv
src/gpb_if.sv
src/goal_post_pair_and_ball_select.sv
tb/sv/goal_post_pair_and_ball_select_tb.sv
